// ===== design/omuart_pkg.sv =====
// Shared constants and codes for the oversampled multichannel UART.
`timescale 1ns / 1ps
package omuart_pkg;
  localparam int CHANNELS    = 4;
  localparam int DATA_BITS   = 8;
  localparam int RX_DEPTH    = 64;
  localparam int TX_DEPTH    = 64;
  localparam int OVERSAMPLE  = 5;
  localparam int MID_OFFSET  = 2;
  localparam int RX_AW       = $clog2(RX_DEPTH);
  localparam int TX_AW       = $clog2(TX_DEPTH);
  localparam int RX_CW       = $clog2(RX_DEPTH + 1);
  localparam int TX_LW       = 7;
  localparam int PH_W        = 3;
  localparam int BC_W        = 4;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_LOAD = 2'd1,
    ACT_POP  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;
endpackage

// ===== design/oversampled_multichannel_uart.sv =====
// Multichannel 8N1 UART with oversampled receive, transmit buffers and receive FIFOs.
`timescale 1ns / 1ps
// Each request is one tick, load, pop or no-op; a request can be taken every clock cycle
// unless the response path is stalled. Its response passes through a request stage (where the
// per-channel FIFO and transmit buffer RAMs are read) and then an output register. A stalled
// response never blocks the next request while a slot is free. Each channel owns a 64-byte
// receive FIFO and a 64-byte transmit buffer RAM with registered reads; the transmit byte in
// flight is read continuously at the current send index. No clearing pass is needed after reset.
module oversampled_multichannel_uart (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [1:0] in_channel,
  input  logic [3:0] in_rx_pins,
  input  logic [7:0] in_tx_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_tx_pins,
  output logic [3:0] out_tx_busy,
  output logic [7:0] out_rx_byte,
  output logic       out_rx_valid,
  output logic [1:0] out_status,
  output logic [3:0] out_frame_error,
  output logic [3:0] out_rx_overflow,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);
  import omuart_pkg::*;

  logic [3:0]      enable_r;
  logic [PH_W-1:0] phase_r, phase_nxt, mid_phase;

  logic [BC_W-1:0]  rx_cnt_r   [CHANNELS], rx_cnt_nxt   [CHANNELS];
  logic [7:0]       rx_shift_r [CHANNELS], rx_shift_nxt [CHANNELS];
  logic [PH_W-1:0]  rx_sph_r   [CHANNELS], rx_sph_nxt   [CHANNELS];
  logic             rx_arm_r   [CHANNELS], rx_arm_nxt   [CHANNELS];
  logic [BC_W-1:0]  tx_cnt_r   [CHANNELS], tx_cnt_nxt   [CHANNELS];
  logic [TX_LW-1:0] tx_idx_r   [CHANNELS], tx_idx_nxt   [CHANNELS];
  logic [TX_LW-1:0] tx_len_r   [CHANNELS], tx_len_nxt   [CHANNELS];
  logic             tx_act_r   [CHANNELS], tx_act_nxt   [CHANNELS];
  logic             tx_line_r  [CHANNELS], tx_line_nxt  [CHANNELS];
  logic [RX_AW-1:0] head_r     [CHANNELS], head_nxt     [CHANNELS];
  logic [RX_AW-1:0] tail_r     [CHANNELS], tail_nxt     [CHANNELS];
  logic [RX_CW-1:0] count_r    [CHANNELS], count_nxt    [CHANNELS];

  logic [7:0] tx_mem_r [CHANNELS][TX_DEPTH];
  logic [7:0] rx_mem_r [CHANNELS][RX_DEPTH];
  logic [7:0] tx_rd_r  [CHANNELS];
  logic [7:0] rx_rd_r  [CHANNELS];
  logic       tx_we    [CHANNELS];
  logic       rx_we    [CHANNELS];

  logic       in_acc, s1_adv;
  logic       s1_v_r, s1_pop_r;
  logic [1:0] s1_ch_r;
  logic [3:0] s1_pins_r, s1_busy_r, s1_ferr_r, s1_ovf_r;
  status_t    s1_status_r, status_nxt;
  logic       pop_nxt;
  logic [3:0] pins_nxt, busy_nxt, ferr_nxt, ovf_nxt;
  logic [TX_LW-1:0] idx_inc;
  logic [TX_LW-1:0] len_inc;
  action_t    act;

  assign act       = action_t'(in_action);
  assign s1_adv    = s1_v_r && (!out_valid || out_ready);
  assign in_ready  = !s1_v_r || s1_adv;
  assign in_acc    = in_valid && in_ready;
  assign mid_phase = (phase_r >= PH_W'(OVERSAMPLE - MID_OFFSET)) ?
                     phase_r - PH_W'(OVERSAMPLE - MID_OFFSET) : phase_r + PH_W'(MID_OFFSET);

  always_comb begin
    phase_nxt  = phase_r;
    status_nxt = ST_OK;
    pop_nxt    = 1'b0;
    ferr_nxt   = '0;
    ovf_nxt    = '0;
    idx_inc    = '0;
    len_inc    = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      rx_cnt_nxt[c]   = rx_cnt_r[c];
      rx_shift_nxt[c] = rx_shift_r[c];
      rx_sph_nxt[c]   = rx_sph_r[c];
      rx_arm_nxt[c]   = rx_arm_r[c];
      tx_cnt_nxt[c]   = tx_cnt_r[c];
      tx_idx_nxt[c]   = tx_idx_r[c];
      tx_len_nxt[c]   = tx_len_r[c];
      tx_act_nxt[c]   = tx_act_r[c];
      tx_line_nxt[c]  = tx_line_r[c];
      head_nxt[c]     = head_r[c];
      tail_nxt[c]     = tail_r[c];
      count_nxt[c]    = count_r[c];
      tx_we[c]        = 1'b0;
      rx_we[c]        = 1'b0;
    end
    case (act)
      ACT_TICK: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (rx_cnt_r[c] == '0 && !rx_arm_r[c] && !in_rx_pins[c]) begin
            rx_sph_nxt[c] = mid_phase;
            rx_arm_nxt[c] = 1'b1;
          end
          if (rx_sph_nxt[c] == phase_r && enable_r[c]) begin
            if (rx_cnt_r[c] == '0) begin
              if (!in_rx_pins[c]) begin
                rx_shift_nxt[c] = '0;
                rx_cnt_nxt[c]   = BC_W'(1);
              end
            end else if (rx_cnt_r[c] <= BC_W'(DATA_BITS)) begin
              rx_shift_nxt[c] = rx_shift_r[c] |
                                (8'(in_rx_pins[c]) << 3'(rx_cnt_r[c] - BC_W'(1)));
              rx_cnt_nxt[c]   = rx_cnt_r[c] + BC_W'(1);
            end else begin
              rx_cnt_nxt[c] = '0;
              rx_arm_nxt[c] = 1'b0;
              if (!in_rx_pins[c]) begin
                ferr_nxt[c] = 1'b1;
              end else if (count_r[c] >= RX_CW'(RX_DEPTH)) begin
                ovf_nxt[c] = 1'b1;
              end else begin
                rx_we[c]     = 1'b1;
                tail_nxt[c]  = tail_r[c] + RX_AW'(1);
                count_nxt[c] = count_r[c] + RX_CW'(1);
              end
            end
          end
          if (phase_r == '0 && tx_act_r[c]) begin
            if (tx_cnt_r[c] == '0) begin
              tx_line_nxt[c] = 1'b0;
              tx_cnt_nxt[c]  = BC_W'(1);
            end else if (tx_cnt_r[c] <= BC_W'(DATA_BITS)) begin
              tx_line_nxt[c] = tx_rd_r[c][3'(tx_cnt_r[c] - BC_W'(1))];
              tx_cnt_nxt[c]  = tx_cnt_r[c] + BC_W'(1);
            end else if (tx_cnt_r[c] == BC_W'(DATA_BITS + 1)) begin
              tx_line_nxt[c] = 1'b1;
              tx_cnt_nxt[c]  = tx_cnt_r[c] + BC_W'(1);
            end else begin
              tx_cnt_nxt[c] = '0;
              idx_inc       = tx_idx_r[c] + TX_LW'(1);
              if (idx_inc >= tx_len_r[c]) begin
                tx_act_nxt[c] = 1'b0;
                tx_idx_nxt[c] = '0;
                tx_len_nxt[c] = '0;
              end else begin
                tx_idx_nxt[c] = idx_inc;
              end
            end
          end
        end
        phase_nxt = (phase_r >= PH_W'(OVERSAMPLE - 1)) ? '0 : phase_r + PH_W'(1);
      end
      ACT_LOAD: begin
        if ({1'b0, in_channel} >= 3'(CHANNELS) || tx_act_r[in_channel]) begin
          status_nxt = ST_BUSY;
        end else begin
          len_inc = tx_len_r[in_channel];
          if (tx_len_r[in_channel] < TX_LW'(TX_DEPTH)) begin
            tx_we[in_channel] = 1'b1;
            len_inc           = tx_len_r[in_channel] + TX_LW'(1);
          end else begin
            status_nxt = ST_FULL;
          end
          tx_len_nxt[in_channel] = len_inc;
          if (in_last_byte && len_inc != '0) begin
            tx_idx_nxt[in_channel] = '0;
            tx_cnt_nxt[in_channel] = '0;
            tx_act_nxt[in_channel] = 1'b1;
          end
        end
      end
      ACT_POP: begin
        if ({1'b0, in_channel} >= 3'(CHANNELS) || count_r[in_channel] == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          pop_nxt               = 1'b1;
          head_nxt[in_channel]  = head_r[in_channel] + RX_AW'(1);
          count_nxt[in_channel] = count_r[in_channel] - RX_CW'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    for (int c = 0; c < CHANNELS; c++) begin
      pins_nxt[c] = tx_line_nxt[c];
      busy_nxt[c] = tx_act_nxt[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 4'd1;
    end else if (cfg_we) begin
      enable_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        rx_cnt_r[c]   <= '0;
        rx_shift_r[c] <= '0;
        rx_sph_r[c]   <= '0;
        rx_arm_r[c]   <= 1'b0;
        tx_cnt_r[c]   <= '0;
        tx_idx_r[c]   <= '0;
        tx_len_r[c]   <= '0;
        tx_act_r[c]   <= 1'b0;
        tx_line_r[c]  <= 1'b1;
        head_r[c]     <= '0;
        tail_r[c]     <= '0;
        count_r[c]    <= '0;
      end
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      for (int c = 0; c < CHANNELS; c++) begin
        rx_cnt_r[c]   <= rx_cnt_nxt[c];
        rx_shift_r[c] <= rx_shift_nxt[c];
        rx_sph_r[c]   <= rx_sph_nxt[c];
        rx_arm_r[c]   <= rx_arm_nxt[c];
        tx_cnt_r[c]   <= tx_cnt_nxt[c];
        tx_idx_r[c]   <= tx_idx_nxt[c];
        tx_len_r[c]   <= tx_len_nxt[c];
        tx_act_r[c]   <= tx_act_nxt[c];
        tx_line_r[c]  <= tx_line_nxt[c];
        head_r[c]     <= head_nxt[c];
        tail_r[c]     <= tail_nxt[c];
        count_r[c]    <= count_nxt[c];
      end
    end
  end

  // Per-channel RAMs; the transmit byte in flight is re-read every cycle.
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (in_acc && tx_we[c]) begin
        tx_mem_r[c][tx_len_r[c][TX_AW-1:0]] <= in_tx_byte;
      end
      if (in_acc && rx_we[c]) begin
        rx_mem_r[c][tail_r[c]] <= rx_shift_r[c];
      end
      tx_rd_r[c] <= tx_mem_r[c][tx_idx_r[c][TX_AW-1:0]];
      if (in_acc) begin
        rx_rd_r[c] <= rx_mem_r[c][head_r[c]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pop_r    <= pop_nxt;
      s1_ch_r     <= in_channel;
      s1_pins_r   <= pins_nxt;
      s1_busy_r   <= busy_nxt;
      s1_ferr_r   <= ferr_nxt;
      s1_ovf_r    <= ovf_nxt;
      s1_status_r <= status_nxt;
    end
    if (s1_adv) begin
      out_tx_pins     <= s1_pins_r;
      out_tx_busy     <= s1_busy_r;
      out_rx_byte     <= s1_pop_r ? rx_rd_r[s1_ch_r] : 8'd0;
      out_rx_valid    <= s1_pop_r;
      out_status      <= s1_status_r;
      out_frame_error <= s1_ferr_r;
      out_rx_overflow <= s1_ovf_r;
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[0] <= RX_CW'(RX_DEPTH))
    else $error("receive FIFO count beyond depth");
  a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
    tx_act_r[0] |-> tx_len_r[0] != '0)
    else $error("transmitter active with empty buffer");
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rx_valid |-> out_status == ST_OK)
    else $error("popped byte with error status");
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_error & out_rx_overflow) == 4'd0)
    else $error("frame error and overflow on same channel");
endmodule

// ===== sim/uart_checker.sv =====
// Checker for the oversampled multichannel UART: predicts each response and compares it.
`timescale 1ns / 1ps
module uart_checker
  import omuart_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [1:0] in_channel,
  input  logic [3:0] in_rx_pins,
  input  logic [7:0] in_tx_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] out_tx_pins,
  input  logic [3:0] out_tx_busy,
  input  logic [7:0] out_rx_byte,
  input  logic       out_rx_valid,
  input  logic [1:0] out_status,
  input  logic [3:0] out_frame_error,
  input  logic [3:0] out_rx_overflow,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  output int         fail_count,
  output int         pending_count
);

  typedef struct packed {
    logic [3:0] tx_pins;
    logic [3:0] tx_busy;
    logic [7:0] rx_byte;
    logic       rx_valid;
    status_t    status;
    logic [3:0] frame_error;
    logic [3:0] rx_overflow;
  } uart_resp_t;

  uart_resp_t resp_q[$];

  logic [3:0] rx_en;
  int         phase;
  int         rbits[CHANNELS], rsamp[CHANNELS], tbits[CHANNELS], tidx[CHANNELS];
  int         tlen[CHANNELS], fhead[CHANNELS], ftail[CHANNELS], fcnt[CHANNELS];
  logic [7:0] rshift[CHANNELS];
  logic       rarmed[CHANNELS], tact[CHANNELS], tline[CHANNELS];
  logic [7:0] tstore[CHANNELS][TX_DEPTH];
  logic [7:0] rfifo[CHANNELS][RX_DEPTH];

  function automatic uart_resp_t predict_uart(action_t act, int ch, logic [3:0] pins,
                                               logic [7:0] txb, logic last);
    uart_resp_t r;
    logic b;
    int n;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_TICK: begin
        for (int c = 0; c < CHANNELS; c++) begin
          b = pins[c];
          if (rbits[c] == 0 && !rarmed[c] && !b) begin
            rsamp[c] = (phase + MID_OFFSET) % OVERSAMPLE;
            rarmed[c] = 1;
          end
          if (rsamp[c] == phase && rx_en[c]) begin
            if (rbits[c] == 0) begin
              if (!b) begin
                rshift[c] = '0;
                rbits[c] = 1;
              end
            end else if (rbits[c] <= DATA_BITS) begin
              rshift[c][rbits[c]-1] = b;
              rbits[c]++;
            end else begin
              rbits[c] = 0;
              rarmed[c] = 0;
              if (!b) r.frame_error[c] = 1;
              else if (fcnt[c] >= RX_DEPTH) r.rx_overflow[c] = 1;
              else begin
                rfifo[c][ftail[c]] = rshift[c];
                ftail[c] = (ftail[c] + 1) % RX_DEPTH;
                fcnt[c]++;
              end
            end
          end
        end
        if (phase == 0) begin
          for (int c = 0; c < CHANNELS; c++) begin
            n = tbits[c];
            if (tact[c]) begin
              if (n == 0) begin
                tline[c] = 0;
                tbits[c] = 1;
              end else if (n <= DATA_BITS) begin
                tline[c] = tstore[c][tidx[c]][n-1];
                tbits[c]++;
              end else if (n == DATA_BITS + 1) begin
                tline[c] = 1;
                tbits[c]++;
              end else begin
                tbits[c] = 0;
                tidx[c]++;
                if (tidx[c] >= tlen[c]) begin
                  tact[c] = 0;
                  tidx[c] = 0;
                  tlen[c] = 0;
                end
              end
            end
          end
        end
        phase = (phase + 1) % OVERSAMPLE;
      end
      ACT_LOAD: begin
        if (tact[ch]) r.status = ST_BUSY;
        else begin
          if (tlen[ch] < TX_DEPTH) begin
            tstore[ch][tlen[ch]] = txb;
            tlen[ch]++;
          end else r.status = ST_FULL;
          if (last && tlen[ch] > 0) begin
            tidx[ch] = 0;
            tbits[ch] = 0;
            tact[ch] = 1;
          end
        end
      end
      ACT_POP: begin
        if (fcnt[ch] == 0) r.status = ST_EMPTY;
        else begin
          r.rx_byte = rfifo[ch][fhead[ch]];
          r.rx_valid = 1;
          fhead[ch] = (fhead[ch] + 1) % RX_DEPTH;
          fcnt[ch]--;
        end
      end
      default: ;
    endcase
    for (int c = 0; c < CHANNELS; c++) begin
      r.tx_pins[c] = tline[c];
      r.tx_busy[c] = tact[c];
    end
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  assign pending_count = resp_q.size();

  always @(posedge clk) begin
    uart_resp_t e;
    if (!rst_n) begin
      rx_en <= 4'd1;
      phase = 0;
      fail_count = 0;
      resp_q.delete();
      for (int c = 0; c < CHANNELS; c++) begin
        rbits[c] = 0; rsamp[c] = 0; tbits[c] = 0; tidx[c] = 0; tlen[c] = 0;
        fhead[c] = 0; ftail[c] = 0; fcnt[c] = 0; rshift[c] = 0;
        rarmed[c] = 0; tact[c] = 0; tline[c] = 1;
      end
    end else begin
      if (cfg_we) rx_en <= cfg_wdata;
      if (in_valid && in_ready)
        resp_q.push_back(predict_uart(action_t'(in_action), in_channel, in_rx_pins,
                                      in_tx_byte, in_last_byte));
      if (out_valid && out_ready) begin
        if (resp_q.size() == 0) begin
          $error("response with no request outstanding");
          fail_count++;
        end else begin
          e = resp_q.pop_front();
          check_field("tx_pins", e.tx_pins, out_tx_pins);
          check_field("tx_busy", e.tx_busy, out_tx_busy);
          check_field("rx_byte", e.rx_byte, out_rx_byte);
          check_field("rx_valid", e.rx_valid, out_rx_valid);
          check_field("status", e.status, out_status);
          check_field("frame_error", e.frame_error, out_frame_error);
          check_field("rx_overflow", e.rx_overflow, out_rx_overflow);
        end
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the UART testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import omuart_pkg::*;

  logic       clk, rst_n;
  logic       in_valid, in_ready, in_last_byte;
  logic [1:0] in_action, in_channel;
  logic [3:0] in_rx_pins;
  logic [7:0] in_tx_byte;
  logic       out_valid, out_ready, out_rx_valid;
  logic [3:0] out_tx_pins, out_tx_busy, out_frame_error, out_rx_overflow;
  logic [7:0] out_rx_byte;
  logic [1:0] out_status;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  int         fail_count, pending_count;
  int         cycle_count;
  int         burst_left;
  logic [3:0] line_lvl;

  oversampled_multichannel_uart dut (.*);
  uart_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver stalls on its own pattern: long ready stretches and stall runs.
  initial begin
    int k;
    out_ready = 1'b1;
    k = 0;
    forever begin
      @(negedge clk);
      k++;
      if (k % 300 < 100) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_req(action_t act, logic [1:0] ch, logic [3:0] pins,
                          logic [7:0] txb, logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_channel <= ch;
    in_rx_pins <= pins;
    in_tx_byte <= txb;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_config(logic [3:0] mask);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mask;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drive a whole frame on channel ch as 5 ticks per bit; others idle high or random.
  task automatic send_frame(logic [1:0] ch, logic [7:0] data, logic stop, logic noisy);
    logic [9:0] bits;
    logic [3:0] p;
    bits = {stop, data, 1'b0};
    for (int i = 0; i < 10; i++)
      for (int s = 0; s < OVERSAMPLE; s++) begin
        p = noisy ? 4'($urandom) : 4'hF;
        p[ch] = bits[i];
        send_req(ACT_TICK, ch, p, 8'($urandom), 1'($urandom));
      end
  endtask

  initial begin
    logic [3:0] masks[4];
    int r;
    masks = '{4'hF, 4'h0, 4'h5, 4'hA};
    cycle_count = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_action = ACT_TICK; in_channel = 2'd0; in_rx_pins = 4'hF;
    in_tx_byte = 8'd0; in_last_byte = 1'b0; cfg_we = 1'b0; cfg_wdata = 4'd0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: empty pop, every action, load extremes, full buffer, busy reject.
    send_req(ACT_POP, 2'd0, 4'hF, 8'h00, 1'b0);
    send_req(ACT_NONE, 2'd3, 4'h0, 8'hFF, 1'b1);
    send_req(ACT_LOAD, 2'd1, 4'hF, 8'h00, 1'b0);
    send_req(ACT_LOAD, 2'd1, 4'hF, 8'hFF, 1'b1);
    send_req(ACT_LOAD, 2'd1, 4'hF, 8'hA5, 1'b0);
    send_req(ACT_LOAD, 2'd2, 4'hF, 8'h11, 1'b1);
    send_frame(2'd0, 8'hFF, 1'b1, 1'b0);
    send_frame(2'd0, 8'h00, 1'b0, 1'b0);
    send_req(ACT_POP, 2'd0, 4'hF, 8'h00, 1'b0);
    send_req(ACT_POP, 2'd0, 4'hF, 8'h00, 1'b0);
    // Fill a tx buffer past full, with the last mark on the overflowing load.
    for (int i = 0; i < TX_DEPTH + 1; i++)
      send_req(ACT_LOAD, 2'd3, 4'hF, 8'(i * 37), i == TX_DEPTH);
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_config(masks[ph]);
      for (int n = 0; n < 14; n++) begin
        r = $urandom_range(0, 99);
        if (r < 15) send_frame(2'($urandom), 8'($urandom), $urandom_range(0, 7) != 0,
                               1'($urandom_range(0, 1)));
        else if (r < 35) begin
          line_lvl = 4'($urandom);
          send_req(ACT_TICK, 2'($urandom), line_lvl, 8'($urandom), 1'($urandom));
        end else if (r < 60)
          send_req(ACT_LOAD, 2'($urandom), 4'($urandom), 8'($urandom),
                   $urandom_range(0, 3) == 0);
        else if (r < 92) send_req(ACT_POP, 2'($urandom), 4'($urandom), 8'($urandom), 1'b0);
        else send_req(ACT_NONE, 2'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
      end
    end
    drain_and_config(4'h1);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== oversampled_multichannel_uart.f =====
design/omuart_pkg.sv
design/oversampled_multichannel_uart.sv
sim/uart_checker.sv
sim/tb_top.sv
